// File: rtl/ech_pkg.sv
// package: shared types, constants and codes of the edge coverage hit map
`timescale 1ns / 1ps
package ech_pkg;

  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned EDGE_W      = 16;
  localparam int unsigned HIT_W       = 8;
  localparam int unsigned COVER_W     = 17;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned MAP_IDX_W   = 16;
  localparam int unsigned CMDQ_DEPTH  = 4;
  localparam int unsigned OUTQ_DEPTH  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_START  = 2'd0,
    CFG_CODE_END    = 2'd1,
    CFG_TRACE_ALL   = 2'd2
  } ech_cfg_e;

  typedef enum logic {
    OP_BLOCK = 1'b0,
    OP_READ  = 1'b1
  } ech_op_e;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] block_address;
    logic [EDGE_W-1:0] read_index;
  } ech_in_t;

  typedef struct packed {
    logic               counted;
    logic [EDGE_W-1:0]  edge_index;
    logic [HIT_W-1:0]   hit_value;
    logic [COVER_W-1:0] covered_entries;
  } ech_out_t;

  typedef struct packed {
    logic              update;
    logic              zero_hit;
    logic [EDGE_W-1:0] edge_index;
  } ech_cmd_t;

endpackage

// File: rtl/ech_fifo.sv
// module: small register fifo used between the pipeline parts
`timescale 1ns / 1ps
module ech_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ech_front.sv
// module: front end, configuration registers, range filter and edge index hashing
`timescale 1ns / 1ps
module ech_front import ech_pkg::*; #(
  parameter int unsigned MapIdxW = MAP_IDX_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push_i,
  input  ech_in_t               in_i,
  output logic                  full_o,
  input  logic                  busy_i,
  input  logic                  cq_full_i,
  output logic                  cq_push_o,
  output ech_cmd_t              cq_cmd_o,
  output logic [MapIdxW-1:0]    cq_idx_o
);

  localparam logic [32:0] MapEntries = 33'd1 << MapIdxW;

  logic [ADDR_W-1:0] code_start_q, code_end_q, prev_q, prev_d;
  logic              trace_all_q;
  logic              accept, in_code, counted, read_ok;
  logic [MapIdxW-1:0] slot;

  assign full_o  = cq_full_i || busy_i;
  assign accept  = push_i && !full_o;
  assign in_code = (in_i.block_address >= code_start_q) && (in_i.block_address < code_end_q);
  assign counted = (in_i.opcode == OP_BLOCK) && (trace_all_q || in_code);
  assign read_ok = ({17'd0, in_i.read_index} < MapEntries);
  assign slot    = MapIdxW'((prev_q >> 1) ^ in_i.block_address);

  always_comb begin
    cq_cmd_o = '0;
    cq_idx_o = slot;
    prev_d   = prev_q;
    if (in_i.opcode == OP_READ) begin
      cq_cmd_o.zero_hit   = !read_ok;
      cq_cmd_o.edge_index = in_i.read_index;
      cq_idx_o            = MapIdxW'(in_i.read_index);
    end else if (counted) begin
      cq_cmd_o.update     = 1'b1;
      cq_cmd_o.edge_index = EDGE_W'(slot);
      if (accept) begin
        prev_d = in_i.block_address;
      end
    end else begin
      cq_cmd_o.zero_hit = 1'b1;
    end
  end

  assign cq_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_start_q <= '0;
      code_end_q   <= '0;
      trace_all_q  <= 1'b0;
      prev_q       <= '0;
    end else begin
      prev_q <= prev_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CODE_START: code_start_q <= cfg_data_i;
          CFG_CODE_END:   code_end_q   <= cfg_data_i;
          CFG_TRACE_ALL:  trace_all_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/ech_back.sv
// module: back end, hit map memory with read-modify-write and clearing sweep
`timescale 1ns / 1ps
module ech_back import ech_pkg::*; #(
  parameter int unsigned MapIdxW = MAP_IDX_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cq_empty_i,
  input  ech_cmd_t           cq_cmd_i,
  input  logic [MapIdxW-1:0] cq_idx_i,
  output logic               cq_pop_o,
  output logic               busy_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output ech_out_t           res_o
);

  localparam int unsigned MapEntries = 1 << MapIdxW;

  logic [HIT_W-1:0]   mem_q [MapEntries];
  logic [HIT_W-1:0]   rdata_q;

  logic               clearing_q;
  logic [MapIdxW-1:0] clr_idx_q;

  logic               s2_valid_q, s2_valid_d;
  ech_cmd_t           s2_cmd_q;
  logic [MapIdxW-1:0] s2_idx_q;

  logic               fwd_valid_q;
  logic [MapIdxW-1:0] fwd_idx_q;
  logic [HIT_W-1:0]   fwd_data_q;

  logic [COVER_W-1:0] nz_q, nz_d;

  logic               issue, s2_fire, s2_write, mem_we;
  logic [MapIdxW-1:0] mem_waddr;
  logic [HIT_W-1:0]   mem_wdata, old_val, new_val;

  assign s2_fire  = s2_valid_q && !res_full_i;
  assign s2_write = s2_fire && s2_cmd_q.update;
  assign issue    = !cq_empty_i && !clearing_q && (!s2_valid_q || s2_fire);
  assign cq_pop_o = issue;
  assign busy_o   = clearing_q;

  assign old_val = (fwd_valid_q && (fwd_idx_q == s2_idx_q)) ? fwd_data_q : rdata_q;
  assign new_val = old_val + 1'b1;

  assign mem_we    = clearing_q || s2_write;
  assign mem_waddr = clearing_q ? clr_idx_q : s2_idx_q;
  assign mem_wdata = clearing_q ? '0 : new_val;

  always_comb begin
    nz_d = nz_q;
    if (s2_write) begin
      if (old_val == '0) begin
        nz_d = nz_q + 1'b1;
      end else if (new_val == '0) begin
        nz_d = nz_q - 1'b1;
      end
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (issue) begin
      s2_valid_d = 1'b1;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_o                 = '0;
    res_o.counted         = s2_cmd_q.update;
    res_o.edge_index      = s2_cmd_q.edge_index;
    res_o.covered_entries = nz_d;
    if (s2_cmd_q.update) begin
      res_o.hit_value = new_val;
    end else if (!s2_cmd_q.zero_hit) begin
      res_o.hit_value = old_val;
    end
  end

  assign res_push_o = s2_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      nz_q        <= '0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      s2_valid_q <= s2_valid_d;
      nz_q       <= nz_d;
      if (s2_write) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_cmd_q <= cq_cmd_i;
      s2_idx_q <= cq_idx_i;
    end
    if (s2_write) begin
      fwd_idx_q  <= s2_idx_q;
      fwd_data_q <= new_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata_q <= mem_q[cq_idx_i];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing_q |-> !issue && !s2_valid_q)
    else $error("transaction issued during map clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> $past(clr_idx_q) == '1)
    else $error("clearing sweep ended early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s2_fire |=> s2_valid_q && $stable(s2_idx_q) && $stable(s2_cmd_q))
    else $error("stalled transaction lost its slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(s2_write) |-> $stable(nz_q))
    else $error("covered count moved without a map update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s2_write) |-> nz_q == $past(nz_q) || nz_q == $past(nz_q) + 1'b1
                        || nz_q == $past(nz_q) - 1'b1)
    else $error("covered count stepped by more than one");

endmodule

// File: rtl/edge_coverage_hit_map.sv
// top level: edge coverage hit map with decoupled classify front and map update back
// path: a transaction goes through the command queue, the map read stage and the result queue
// throughput: one per cycle unless stalled, set by the single read and write port of the map
// reset: the map is swept to zero with full high; config writes still taken
// reset clears the code range, the previous block address and the covered count
`timescale 1ns / 1ps
module edge_coverage_hit_map import ech_pkg::*; #(
  parameter int unsigned MapIdxW = MAP_IDX_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  input  ech_in_t               in_i,
  output logic                  full,
  input  logic                  pop,
  output ech_out_t              out_o,
  output logic                  empty
);

  localparam int unsigned CmdW = $bits(ech_cmd_t) + MapIdxW;

  logic               busy, cq_full, cq_push, cq_pop, cq_empty;
  ech_cmd_t           fe_cmd, be_cmd;
  logic [MapIdxW-1:0] fe_idx, be_idx;
  logic [CmdW-1:0]    cq_rdata;
  logic               res_full, res_push;
  ech_out_t           res;

  ech_front #(.MapIdxW(MapIdxW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_i       (in_i),
    .full_o     (full),
    .busy_i     (busy),
    .cq_full_i  (cq_full),
    .cq_push_o  (cq_push),
    .cq_cmd_o   (fe_cmd),
    .cq_idx_o   (fe_idx)
  );

  ech_fifo #(.Width(CmdW), .Depth(CMDQ_DEPTH)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  ({fe_cmd, fe_idx}),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .data_o  (cq_rdata),
    .empty_o (cq_empty)
  );

  assign be_cmd = ech_cmd_t'(cq_rdata[CmdW-1:MapIdxW]);
  assign be_idx = cq_rdata[MapIdxW-1:0];

  ech_back #(.MapIdxW(MapIdxW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cq_empty_i (cq_empty),
    .cq_cmd_i   (be_cmd),
    .cq_idx_i   (be_idx),
    .cq_pop_o   (cq_pop),
    .busy_o     (busy),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  ech_fifo #(.Width($bits(ech_out_t)), .Depth(OUTQ_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_o),
    .empty_o (empty)
  );

endmodule

// File: tb/sv/testbench.sv
// testbench: directed and random traffic, prediction and checking for the edge coverage hit map
`timescale 1ns / 1ps
module testbench;
  import ech_pkg::*;

  localparam int unsigned HALF_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 300000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned MAP_SIZE       = 1 << MAP_IDX_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0]    ADDR_MAX  = '1;

  typedef enum int unsigned {
    MIX_ANYWHERE,
    MIX_RANGE,
    MIX_LOOPS,
    MIX_FULL_SPAN
  } traffic_mix_e;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push       = 1'b0;
  ech_in_t               in_i       = '0;
  logic                  full;
  logic                  pop;
  ech_out_t              out_o;
  logic                  empty;

  edge_coverage_hit_map dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .in_i       (in_i),
    .full       (full),
    .pop        (pop),
    .out_o      (out_o),
    .empty      (empty)
  );

  // shadow of the map, the edge history and the filter registers
  logic [HIT_W-1:0]   hit_map_model [MAP_SIZE];
  logic [ADDR_W-1:0]  prev_block_model;
  logic [COVER_W-1:0] covered_model;
  logic [EDGE_W-1:0]  last_slot_model;
  logic [ADDR_W-1:0]  code_start_model;
  logic [ADDR_W-1:0]  code_end_model;
  logic               trace_all_model;
  ech_out_t           pending_hits [$];

  int unsigned mismatches        = 0;
  int unsigned sent_count        = 0;
  int unsigned counted_count     = 0;
  int unsigned read_count        = 0;
  int unsigned wrap_count        = 0;
  int unsigned quiet_cycles      = 0;
  int unsigned receiver_hold_req = 0;
  bit          idling_on         = 1'b1;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic ech_in_t block_item(input logic [ADDR_W-1:0] addr);
    ech_in_t item;
    item.opcode        = OP_BLOCK;
    item.block_address = addr;
    item.read_index    = EDGE_W'($urandom);
    return item;
  endfunction

  function automatic ech_in_t read_item(input logic [EDGE_W-1:0] idx);
    ech_in_t item;
    item.opcode        = OP_READ;
    item.block_address = rand_addr();
    item.read_index    = idx;
    return item;
  endfunction

  function automatic logic [EDGE_W-1:0] pick_read_index();
    if ($urandom_range(0, 1) == 0) return last_slot_model;
    return EDGE_W'($urandom);
  endfunction

  function automatic void apply_hit_event(input ech_in_t item);
    ech_out_t          res;
    logic [EDGE_W-1:0] slot;
    logic [HIT_W-1:0]  old_hit;
    res = '0;
    if (item.opcode == OP_READ) begin
      res.edge_index = item.read_index;
      res.hit_value  = hit_map_model[item.read_index];
      read_count++;
    end else if (trace_all_model || (item.block_address >= code_start_model &&
                                     item.block_address < code_end_model)) begin
      slot    = EDGE_W'((prev_block_model >> 1) ^ item.block_address);
      old_hit = hit_map_model[slot];
      hit_map_model[slot] = old_hit + 1'b1;
      if (old_hit == '0) begin
        covered_model++;
      end else if (hit_map_model[slot] == '0) begin
        covered_model--;
        wrap_count++;
      end
      prev_block_model = item.block_address;
      last_slot_model  = slot;
      res.counted      = 1'b1;
      res.edge_index   = slot;
      res.hit_value    = hit_map_model[slot];
      counted_count++;
    end
    res.covered_entries = covered_model;
    pending_hits.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_item(input ech_in_t item);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (full);
    apply_hit_event(item);
    sent_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CODE_START: code_start_model = data;
      CFG_CODE_END:   code_end_model   = data;
      CFG_TRACE_ALL:  trace_all_model  = data[0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [ADDR_W-1:0] start_addr,
                            input logic [ADDR_W-1:0] end_addr, input logic trace_all);
    wait_idle();
    cfg_write(CFG_CODE_START, start_addr);
    cfg_write(CFG_CODE_END, end_addr);
    cfg_write(CFG_TRACE_ALL, CFG_DATA_W'(trace_all));
  endtask

  task automatic test_reset_state();
    send_item(read_item('0));
    send_item(read_item('1));
    send_item(block_item('0));
    send_item(block_item(ADDR_MAX));
  endtask

  task automatic test_range_edges();
    set_filter(64'h1000, 64'h2000, 1'b0);
    send_item(block_item(64'h0fff));
    send_item(block_item(64'h1000));
    send_item(block_item(64'h1fff));
    send_item(block_item(64'h2000));
    send_item(read_item(last_slot_model));
    set_filter('0, ADDR_MAX, 1'b0);
    send_item(block_item('0));
    send_item(block_item(ADDR_MAX - 1));
    send_item(block_item(ADDR_MAX));
    set_filter(ADDR_MAX, ADDR_MAX, 1'b0);
    send_item(block_item(ADDR_MAX));
    send_item(block_item('0));
    set_filter(64'h2000, 64'h1000, 1'b0);
    send_item(block_item(64'h1800));
  endtask

  task automatic test_trace_everywhere();
    set_filter(64'h2000, 64'h1000, 1'b1);
    send_item(block_item(64'h1800));
    send_item(block_item('0));
    send_item(block_item(ADDR_MAX));
    wait_idle();
    // only bit 0 of the data counts
    cfg_write(CFG_TRACE_ALL, 64'hffff_ffff_ffff_fffe);
    send_item(block_item(64'h1800));
    send_item(read_item(last_slot_model));
  endtask

  task automatic test_spare_register();
    wait_idle();
    cfg_write(CFG_SPARE, ADDR_MAX);
    send_item(block_item(ADDR_MAX));
    wait_idle();
    cfg_write(CFG_TRACE_ALL, 64'h1);
    cfg_write(CFG_SPARE, '0);
    send_item(block_item(64'h1800));
  endtask

  task automatic test_counter_wrap();
    logic [ADDR_W-1:0] loop_addr;
    loop_addr = rand_addr();
    set_filter(rand_addr(), rand_addr(), 1'b1);
    // a block that loops on itself keeps hitting one edge
    repeat (300) send_item(block_item(loop_addr));
    send_item(read_item(last_slot_model));
  endtask

  task automatic test_backpressure();
    set_filter('0, '0, 1'b1);
    receiver_hold_req = LONG_HOLD;
    repeat (60) send_item(block_item(rand_addr()));
  endtask

  task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
    traffic_mix_e      mix;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] loop_pool [4];
    for (int p = 0; p < phases; p++) begin
      mix  = traffic_mix_e'(p % 4);
      base = rand_addr();
      span = ADDR_W'($urandom_range(16, 1 << 20));
      foreach (loop_pool[k]) loop_pool[k] = base + ADDR_W'($urandom_range(0, 255));
      case (mix)
        MIX_ANYWHERE: set_filter(rand_addr(), rand_addr(), 1'b1);
        MIX_RANGE:    set_filter(base, base + span, 1'b0);
        MIX_LOOPS:    set_filter(base, base + 64'd200, 1'($urandom_range(0, 1)));
        default:      set_filter('0, ADDR_MAX, 1'b0);
      endcase
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(read_item(pick_read_index()));
        end else begin
          case (mix)
            MIX_RANGE: begin
              if ($urandom_range(0, 4) == 0) send_item(block_item(rand_addr()));
              else send_item(block_item(base - 64'd8 +
                                        ADDR_W'($urandom_range(0, 32'(span) + 32'd16))));
            end
            MIX_LOOPS: send_item(block_item(loop_pool[$urandom_range(0, 3)]));
            default:   send_item(block_item(rand_addr()));
          endcase
        end
      end
    end
  endtask

  task automatic test_steady_stream();
    wait_idle();
    idling_on = 1'b0;
    test_random_traffic(2, 100);
  endtask

  initial begin : receiver
    int unsigned hold;
    hold = 0;
    pop  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (receiver_hold_req != 0) begin
        hold = receiver_hold_req;
        receiver_hold_req = 0;
      end else if (hold == 0 && idling_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 9);
      end
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    ech_out_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("transaction with nothing pending", 64'(out_o), '0);
      end else begin
        want = pending_hits.pop_front();
        check_field("counted", 64'(out_o.counted), 64'(want.counted));
        check_field("edge_index", 64'(out_o.edge_index), 64'(want.edge_index));
        check_field("hit_value", 64'(out_o.hit_value), 64'(want.hit_value));
        check_field("covered_entries", 64'(out_o.covered_entries),
                    64'(want.covered_entries));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    foreach (hit_map_model[i]) hit_map_model[i] = '0;
    prev_block_model = '0;
    covered_model    = '0;
    last_slot_model  = '0;
    code_start_model = '0;
    code_end_model   = '0;
    trace_all_model  = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_range_edges();
    test_trace_everywhere();
    test_spare_register();
    test_counter_wrap();
    test_backpressure();
    test_random_traffic(6, 220);
    test_steady_stream();
    wait_idle();
    $display("ran %0d transactions: %0d counted block entries, %0d reads, %0d counter wraps",
             sent_count, counted_count, read_count, wrap_count);
    $display("map ended with %0d nonzero entries, %0d mismatches", covered_model, mismatches);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ech_pkg.sv
rtl/ech_fifo.sv
rtl/ech_front.sv
rtl/ech_back.sv
rtl/edge_coverage_hit_map.sv
tb/sv/testbench.sv
